// ----- rtl/rsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster sprite decoder package
// Shared codes, register indexes, widths and the types of the result queue.
// ----------------------------------------------------------------------------
package rsd_pkg;

	localparam int LINE_WIDTH_DEF = 320;
	localparam int QDEPTH         = 4;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 9;

	localparam logic [7:0] CODE_ROW     = 8'hF6;
	localparam logic [7:0] CODE_BRACKET = 8'hF9;
	localparam logic [7:0] CODE_END     = 8'hFF;
	localparam logic [7:0] OFFSET_ABORT = 8'hFF;
	localparam logic [9:0] X_MAX        = 10'd1023;
	localparam logic [7:0] Y_MAX        = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_OFFSET = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_ZERO    = CFG_IDX_W'(3);

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [9:0] x;
		logic [7:0] y;
		logic [7:0] color;
	} res_t;

	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

endpackage

// ----- rtl/rsd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster sprite decoder channels
// Valid/ready channels for stream bytes, result items and register writes.
// ----------------------------------------------------------------------------
interface rsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;

	modport source (output valid, data_byte, first, input ready);
	modport sink (input valid, data_byte, first, output ready);
endinterface

interface rsd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] pixel_address;
	logic [7:0]  pixel_color;
	logic        out_of_range;
	logic        last;

	modport source (output valid, kind, pixel_address, pixel_color, out_of_range, last,
		input ready);
	modport sink (input valid, kind, pixel_address, pixel_color, out_of_range, last,
		output ready);
endinterface

interface rsd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rsd_pkg::CFG_IDX_W-1:0]  index;
	logic [rsd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rsd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster sprite decoder front end
// Holds the registers and the position state, classifies each byte and
// queues the results it causes.
// ----------------------------------------------------------------------------
module rsd_front (
	input  logic            clk,
	input  logic            arst_n,
	rsd_in_if.sink          sprite,
	rsd_cfg_if.sink         cfg,
	input  logic            q_full,
	output logic            push,
	output rsd_pkg::entry_t entry
);

	logic [8:0] origin_x_q;
	logic [7:0] origin_y_q;
	logic [7:0] color_offset_q;
	logic       draw_zero_q;

	logic [9:0] pos_x_q;
	logic [7:0] pos_y_q;
	logic       held_q;
	logic       decoding_q;

	logic        acc;
	logic        abort;
	logic [7:0]  b;
	logic [9:0]  x1;
	logic [9:0]  x2;
	logic [7:0]  col_br;
	logic [7:0]  col_b;
	logic        is_row;
	logic        is_br;
	logic        res_b;
	rsd_pkg::res_t ra;
	rsd_pkg::res_t rb;
	rsd_pkg::res_t rend;

	assign sprite.ready = !q_full;
	assign cfg.ready    = 1'b1;
	assign acc          = sprite.valid && sprite.ready;
	assign b            = sprite.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= 9'd0;
			origin_y_q     <= 8'd0;
			color_offset_q <= 8'd1;
			draw_zero_q    <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rsd_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg.data[8:0];
				rsd_pkg::REG_ORIGIN_Y:     origin_y_q     <= cfg.data[7:0];
				rsd_pkg::REG_COLOR_OFFSET: color_offset_q <= cfg.data[7:0];
				rsd_pkg::REG_DRAW_ZERO:    draw_zero_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		abort  = (color_offset_q == rsd_pkg::OFFSET_ABORT) ||
			(held_q && (b == rsd_pkg::CODE_END));
		x1     = (held_q && (pos_x_q != rsd_pkg::X_MAX)) ? pos_x_q + 10'd1 : pos_x_q;
		x2     = (x1 != rsd_pkg::X_MAX) ? x1 + 10'd1 : x1;
		col_br = rsd_pkg::CODE_BRACKET + color_offset_q - 8'd1;
		col_b  = b + color_offset_q - 8'd1;
		is_row = (b == rsd_pkg::CODE_ROW);
		is_br  = (b == rsd_pkg::CODE_BRACKET);
		res_b  = !is_row && !is_br && ((b != 8'd0) || draw_zero_q);

		ra = '{kind: rsd_pkg::KIND_PIXEL, x: x1, y: pos_y_q, color: col_br};
		rb = '{kind: rsd_pkg::KIND_PIXEL, x: x2, y: pos_y_q,
			color: (b != 8'd0) ? col_b : 8'd0};
		rend = '{kind: rsd_pkg::KIND_END, x: 10'd0, y: 8'd0, color: 8'd0};

		entry.two = 1'b0;
		entry.r0  = rb;
		entry.r1  = rb;
		if (abort) begin
			entry.r0 = rend;
		end else if (held_q) begin
			entry.r0  = ra;
			entry.two = res_b;
		end

		push = acc && !sprite.first && decoding_q && (abort || held_q || res_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= 10'd0;
			pos_y_q    <= 8'd0;
			held_q     <= 1'b0;
			decoding_q <= 1'b0;
		end else if (acc) begin
			if (sprite.first) begin
				pos_x_q    <= {1'b0, origin_x_q};
				pos_y_q    <= origin_y_q;
				held_q     <= 1'b0;
				decoding_q <= 1'b1;
			end else if (decoding_q) begin
				if (abort) begin
					held_q     <= 1'b0;
					decoding_q <= 1'b0;
				end else begin
					held_q <= is_br;
					if (is_row) begin
						pos_x_q <= {1'b0, origin_x_q};
						if (pos_y_q != rsd_pkg::Y_MAX) begin
							pos_y_q <= pos_y_q + 8'd1;
						end
					end else if (is_br) begin
						pos_x_q <= x1;
					end else begin
						pos_x_q <= x2;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/rsd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster sprite decoder result queue
// Short first-in first-out buffer of decoded entries between front and back.
// ----------------------------------------------------------------------------
module rsd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rsd_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output rsd_pkg::entry_t head
);

	localparam int PW = $clog2(rsd_pkg::QDEPTH);
	localparam int CW = $clog2(rsd_pkg::QDEPTH + 1);

	rsd_pkg::entry_t mem_q [rsd_pkg::QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(rsd_pkg::QDEPTH));
	assign empty   = (cnt_q == CW'(0));
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(rsd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(rsd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/rsd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster sprite decoder back end
// Takes queued entries apart into result items, computes the frame buffer
// address and holds each item in the output register until it is taken.
// ----------------------------------------------------------------------------
module rsd_back #(
	parameter int LINE_WIDTH = rsd_pkg::LINE_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  rsd_pkg::entry_t head,
	output logic            pop,
	rsd_out_if.source       pixel
);

	localparam int LW_W = $clog2(LINE_WIDTH + 1);
	localparam int MW   = 8 + LW_W;
	localparam int AW   = ((MW > 16) ? MW : 16) + 1;

	logic          sel_q;
	logic          load;
	logic          take;
	logic          is_last;
	rsd_pkg::res_t cur;
	logic [AW-1:0] addr;

	assign load    = !pixel.valid || pixel.ready;
	assign take    = load && !empty;
	assign cur     = sel_q ? head.r1 : head.r0;
	assign is_last = !head.two || sel_q;
	assign pop     = take && is_last;
	assign addr    = AW'(cur.y) * AW'(LINE_WIDTH) + AW'(cur.x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.valid <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			pixel.valid <= !empty;
			if (take) begin
				sel_q <= !is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel.kind          <= cur.kind;
			pixel.pixel_address <= addr[15:0];
			pixel.pixel_color   <= cur.color;
			pixel.out_of_range  <= |addr[AW-1:16];
			pixel.last          <= is_last;
		end
	end

endmodule

// ----- rtl/raster_sprite_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster sprite decoder core
// Decodes a byte-coded sprite stream into frame buffer pixel writes.
//
//   Channel   Role     Carries
//   sprite    sink     data_byte, first
//   pixel     source   kind, pixel_address, pixel_color, out_of_range, last
//   cfg       sink     index, data (register write)
//
// One byte is taken each cycle while the four-entry result queue has room.
// A byte that causes two results holds the back end until both are taken, so the address
// multiply and output register set the result rate at one per cycle while the pixel channel is ready.
// A stalled pixel channel fills the queue and then holds sprite.ready low.
// Reset clears position, decode state, queue and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module raster_sprite_decoder_core #(
	parameter int LINE_WIDTH = rsd_pkg::LINE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rsd_in_if.sink    sprite,
	rsd_out_if.source pixel,
	rsd_cfg_if.sink   cfg
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	rsd_pkg::entry_t push_entry;
	rsd_pkg::entry_t head;

	rsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sprite (sprite),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	rsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	rsd_back #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (head),
		.pop    (pop),
		.pixel  (pixel)
	);

	a_end_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.kind == rsd_pkg::KIND_END) |-> pixel.last)
		else $error("end item without last");

	a_end_fields_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.kind == rsd_pkg::KIND_END) |->
		(pixel.pixel_address == 16'd0 && pixel.pixel_color == 8'd0 && !pixel.out_of_range))
		else $error("end item with nonzero fields");

	a_queue_drains : assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && (!pixel.valid || pixel.ready)) |=> pixel.valid)
		else $error("queued entry not moved to output");

endmodule
